/* hw/rtl/mtue_pkg.sv */
// Shared types, command codes and lookup functions for the clock string converter.
`timescale 1ns / 1ps
`default_nettype none
package mtue_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_CLEAR  = 3'd1;
  localparam op_t OP_PARSE  = 3'd2;
  localparam op_t OP_DAYS   = 3'd3;
  localparam op_t OP_SCALE  = 3'd4;
  localparam op_t OP_HOUR   = 3'd5;
  localparam op_t OP_MINSEC = 3'd6;
  localparam op_t OP_ZONE   = 3'd7;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned FIELD_W  = 7;
  localparam int unsigned NFIELDS  = 7;
  localparam int unsigned DAYS_W   = 16;

  localparam logic [3:0] POS_SIGN = 4'd12;
  localparam logic [3:0] POS_ZONE = 4'd13;
  localparam logic [3:0] POS_DONE = 4'd14;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [EPOCH_W-1:0] EPOCH_2000    = 32'd946684800;
  localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [EPOCH_W-1:0] EPOCH_BASE    = EPOCH_2000 - SECS_PER_DAY;
  localparam logic [3:0]         MIN_FIELDS    = 4'd6;

  function automatic logic [7:0] literal_of(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h22;
      3'd1: c = 8'h2F;
      3'd2: c = 8'h2F;
      3'd3: c = 8'h2C;
      3'd4: c = 8'h3A;
      3'd5: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:  d = 9'd0;
      4'd2:  d = 9'd31;
      4'd3:  d = 9'd59;
      4'd4:  d = 9'd90;
      4'd5:  d = 9'd120;
      4'd6:  d = 9'd151;
      4'd7:  d = 9'd181;
      4'd8:  d = 9'd212;
      4'd9:  d = 9'd243;
      4'd10: d = 9'd273;
      4'd11: d = 9'd304;
      4'd12: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mtue_ctrl.sv */
// Sequencer for byte intake, epoch computation steps and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module mtue_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output mtue_pkg::dp_cmd_t cmd
);
  import mtue_pkg::*;

  localparam logic [2:0] ST_RX     = 3'd0;
  localparam logic [2:0] ST_DAYS   = 3'd1;
  localparam logic [2:0] ST_SCALE  = 3'd2;
  localparam logic [2:0] ST_HOUR   = 3'd3;
  localparam logic [2:0] ST_MINSEC = 3'd4;
  localparam logic [2:0] ST_ZONE   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready  = (state_r == ST_RX);
  assign out_tvalid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_RX: begin
        if (in_tvalid) begin
          cmd.op = OP_PARSE;
          if (in_tlast) begin
            state_nxt = ST_DAYS;
          end
        end
      end
      ST_DAYS: begin
        cmd.op    = OP_DAYS;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = ST_HOUR;
      end
      ST_HOUR: begin
        cmd.op    = OP_HOUR;
        state_nxt = ST_MINSEC;
      end
      ST_MINSEC: begin
        cmd.op    = OP_MINSEC;
        state_nxt = ST_ZONE;
      end
      ST_ZONE: begin
        cmd.op    = OP_ZONE;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          cmd.op    = OP_CLEAR;
          state_nxt = ST_RX;
        end
      end
      default: begin
        state_nxt = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_last_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> state_r == ST_DAYS)
    else $error("final byte did not start computation");

  a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("intake open while result pending");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 6))
    else $error("result appeared at wrong latency");

endmodule
`default_nettype wire

/* hw/rtl/mtue_dp.sv */
// Parser registers and stepwise epoch accumulator.
`timescale 1ns / 1ps
`default_nettype none
module mtue_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mtue_pkg::dp_cmd_t                 cmd,
  input  logic [mtue_pkg::CHAR_W-1:0]       char_code,
  output logic [mtue_pkg::EPOCH_W-1:0]      epoch_seconds,
  output logic                              ok,
  output logic [mtue_pkg::COUNT_W-1:0]      fields_found
);
  import mtue_pkg::*;

  logic [3:0]         pos_r, pos_nxt;
  logic               dc_r, dc_nxt;
  logic [FIELD_W-1:0] fv_r [NFIELDS];
  logic [FIELD_W-1:0] fv_nxt [NFIELDS];
  logic [7:0]         sign_r, sign_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               fail_r, fail_nxt;
  logic [DAYS_W-1:0]  days_r;
  logic [EPOCH_W-1:0] acc_r;

  logic               stop;
  logic [2:0]         idx;
  logic [3:0]         dig;
  logic               is_digit;
  logic [10:0]        fv_x10;

  logic [FIELD_W-1:0] yy, mon;
  logic [DAYS_W-1:0]  days_calc;
  logic [16:0]        zone_off;

  always_comb begin
    pos_nxt  = pos_r;
    dc_nxt   = dc_r;
    fv_nxt   = fv_r;
    sign_nxt = sign_r;
    cnt_nxt  = cnt_r;
    fail_nxt = fail_r;
    stop     = 1'b0;
    idx      = 3'd0;
    fv_x10   = '0;
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    dig      = 4'(char_code - CH_ZERO);
    for (int p = 0; p < 2; p++) begin
      if (!stop) begin
        if (fail_nxt || pos_nxt >= POS_DONE) begin
          stop = 1'b1;
        end else if (pos_nxt == POS_SIGN) begin
          sign_nxt = char_code;
          cnt_nxt  = cnt_nxt + 1'b1;
          pos_nxt  = POS_ZONE;
          dc_nxt   = 1'b0;
          stop     = 1'b1;
        end else if (!pos_nxt[0]) begin
          if (char_code == literal_of(pos_nxt[3:1])) begin
            pos_nxt = pos_nxt + 1'b1;
          end else begin
            fail_nxt = 1'b1;
          end
          stop = 1'b1;
        end else begin
          idx = (pos_nxt == POS_ZONE) ? 3'd6 : pos_nxt[3:1];
          if (is_digit) begin
            if (!dc_nxt) begin
              fv_nxt[idx] = FIELD_W'(dig);
              cnt_nxt     = cnt_nxt + 1'b1;
              dc_nxt      = 1'b1;
            end else begin
              fv_x10      = 11'(fv_nxt[idx]) * 11'd10 + 11'(dig);
              fv_nxt[idx] = fv_x10[FIELD_W-1:0];
              dc_nxt      = 1'b0;
              pos_nxt     = pos_nxt + 1'b1;
            end
            stop = 1'b1;
          end else if (!dc_nxt) begin
            fail_nxt = 1'b1;
            stop     = 1'b1;
          end else begin
            dc_nxt  = 1'b0;
            pos_nxt = pos_nxt + 1'b1;
          end
        end
      end
    end
  end

  assign yy  = fv_r[0];
  assign mon = fv_r[1];

  always_comb begin
    days_calc = 16'(yy * 16'd365) + 16'((16'(yy) + 16'd3) >> 2)
              + 16'(days_before_month(mon[3:0])) + 16'(fv_r[2]);
    if (mon > 7'd2 && yy[1:0] == 2'b00) begin
      days_calc = days_calc + 16'd1;
    end
  end

  assign zone_off = 17'(fv_r[6]) * 17'd900;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == OP_CLEAR) begin
      pos_r  <= '0;
      dc_r   <= 1'b0;
      sign_r <= CH_PLUS;
      cnt_r  <= '0;
      fail_r <= 1'b0;
      for (int i = 0; i < NFIELDS; i++) begin
        fv_r[i] <= '0;
      end
    end else if (cmd.op == OP_PARSE) begin
      pos_r  <= pos_nxt;
      dc_r   <= dc_nxt;
      sign_r <= sign_nxt;
      cnt_r  <= cnt_nxt;
      fail_r <= fail_nxt;
      fv_r   <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DAYS:   days_r <= days_calc;
      OP_SCALE:  acc_r  <= EPOCH_BASE + 32'(days_r * SECS_PER_DAY);
      OP_HOUR:   acc_r  <= acc_r + 32'(12'(fv_r[3]) * 12'd3600 + 19'd0);
      OP_MINSEC: acc_r  <= acc_r + 32'(13'(fv_r[4]) * 13'd60) + 32'(fv_r[5]);
      OP_ZONE: begin
        if (zone_off != '0) begin
          if (sign_r == CH_PLUS) begin
            acc_r <= acc_r - 32'(zone_off);
          end else if (sign_r == CH_MINUS) begin
            acc_r <= acc_r + 32'(zone_off);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ok            = (cnt_r >= MIN_FIELDS) && (mon >= 7'd1) && (mon <= 7'd12);
  assign epoch_seconds = ok ? acc_r : '0;
  assign fields_found  = cnt_r;

endmodule
`default_nettype wire

/* hw/rtl/modem_timestamp_to_utc_epoch.sv */
// Top level: modem clock string bytes in, UTC Unix seconds out.
// Throughput: one byte accepted per cycle while a string is being received.
// After the final byte is accepted, the result passes through five arithmetic steps (days, scale,
// hour, minute/second, zone; the last four share one accumulator), then the output state.
// Intake is closed from the final byte until the result is taken.
// Reset (rst_n low, synchronous) empties the parser and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module modem_timestamp_to_utc_epoch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] epoch_seconds, [35:32] fields_found, zero fill
  output logic        out_tuser   // ok
);
  import mtue_pkg::*;

  dp_cmd_t            cmd;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic               ok;
  logic [COUNT_W-1:0] fields_found;

  mtue_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mtue_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .char_code     (in_tdata),
    .epoch_seconds (epoch_seconds),
    .ok            (ok),
    .fields_found  (fields_found)
  );

  assign out_tdata = {4'b0000, fields_found, epoch_seconds};
  assign out_tuser = ok;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the modem clock string to UTC epoch converter.
`timescale 1ns / 1ps
module testbench;
  import mtue_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [47:0] SEPARATORS = {CH_COLON, CH_COLON, CH_COMMA,
                                        CH_SLASH, CH_SLASH, CH_QUOTE};
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned HOLD_PERIOD = 1500;
  localparam int unsigned HOLD_LENGTH = 250;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic        ok;
    logic [3:0]  count;
  } utc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  char_req_t   pending_chars[$];
  utc_result_t utc_expected[$];
  logic [7:0]  text_buf[$];
  char_req_t   next_char;
  utc_result_t want;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned chars_queued = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_mode = 0;

  // parser state of the expected behavior
  logic [3:0] p_pos;
  logic [1:0] p_digits;
  logic [6:0] p_fields [7];
  logic [7:0] p_sign;
  logic [3:0] p_matched;
  logic       p_failed;

  modem_timestamp_to_utc_epoch DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic clear_parser();
    int k;
    p_pos = 4'd0;
    p_digits = 2'd0;
    for (k = 0; k < 7; k++) p_fields[k] = 7'd0;
    p_sign = CH_PLUS;
    p_matched = 4'd0;
    p_failed = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    int pass_i;
    int idx;
    bit stop;
    stop = 0;
    for (pass_i = 0; pass_i < 2 && !stop; pass_i++) begin
      if (p_failed || p_pos >= POS_DONE) begin
        stop = 1;
      end else if (p_pos == POS_SIGN) begin
        p_sign = c;
        p_matched = p_matched + 4'd1;
        p_pos = POS_ZONE;
        p_digits = 2'd0;
        stop = 1;
      end else if (!p_pos[0]) begin
        if (c == SEPARATORS[p_pos[3:1]*8 +: 8]) p_pos = p_pos + 4'd1;
        else p_failed = 1'b1;
        stop = 1;
      end else begin
        idx = (p_pos == POS_ZONE) ? 6 : (int'(p_pos) - 1) / 2;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (p_digits == 2'd0) begin
            p_fields[idx] = 7'(c - CH_ZERO);
            p_matched = p_matched + 4'd1;
            p_digits = 2'd1;
          end else begin
            p_fields[idx] = 7'((int'(p_fields[idx]) * 10 + int'(c - CH_ZERO)) & 'h7F);
            p_digits = 2'd0;
            p_pos = p_pos + 4'd1;
          end
          stop = 1;
        end else if (p_digits == 2'd0) begin
          p_failed = 1'b1;
          stop = 1;
        end else begin
          p_digits = 2'd0;
          p_pos = p_pos + 4'd1;
        end
      end
    end
  endtask

  function automatic logic [31:0] utc_seconds();
    longint unsigned yy, mon, days, secs, off;
    int m;
    yy = p_fields[0];
    mon = p_fields[1];
    days = yy * 365 + (yy + 3) / 4;
    for (m = 1; m < mon; m++)
      days += (m == 2) ? 28 : ((m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31);
    if (mon > 2 && yy % 4 == 0) days += 1;
    secs = 64'd946684800 + days * 64'd86400 + p_fields[2] * 64'd86400 - 64'd86400
           + p_fields[3] * 64'd3600 + p_fields[4] * 64'd60 + p_fields[5];
    off = p_fields[6] * 64'd900;
    if (off != 0) begin
      if (p_sign == CH_PLUS) secs -= off;
      else if (p_sign == CH_MINUS) secs += off;
    end
    return secs[31:0];
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'h00;
      in_tlast <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0 || pending_chars.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        next_char = pending_chars.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_char.code;
        in_tlast <= next_char.last;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: own stall pattern plus periodic long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      rx_mode_left = 0;
    end else begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_cycle % HOLD_PERIOD == 400) begin
        hold_left = HOLD_LENGTH;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(10, 80);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (rx_cycle % 5 < 3);
        endcase
      end
    end
  end

  // monitor: check results, then predict from accepted requests
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (out_tvalid && out_tready) begin
        if (utc_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none actual epoch %0d ok %0d count %0d",
                   $time, out_tdata[31:0], out_tuser, out_tdata[35:32]);
          mismatches++;
        end else begin
          want = utc_expected.pop_front();
          if (out_tdata[31:0] !== want.epoch) begin
            $display("%0t: epoch_seconds expected %0d actual %0d",
                     $time, want.epoch, out_tdata[31:0]);
            mismatches++;
          end
          if (out_tuser !== want.ok) begin
            $display("%0t: ok expected %0d actual %0d", $time, want.ok, out_tuser);
            mismatches++;
          end
          if (out_tdata[35:32] !== want.count) begin
            $display("%0t: fields_found expected %0d actual %0d",
                     $time, want.count, out_tdata[35:32]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        parse_char(in_tdata);
        if (in_tlast) begin
          want.ok = (p_matched >= MIN_FIELDS) && (p_fields[1] >= 7'd1) && (p_fields[1] <= 7'd12);
          want.epoch = want.ok ? utc_seconds() : 32'd0;
          want.count = p_matched;
          utc_expected.push_back(want);
          clear_parser();
        end
      end
    end
  end

  task automatic queue_text_buf();
    int k;
    for (k = 0; k < text_buf.size(); k++) begin
      pending_chars.push_back('{code: text_buf[k], last: (k == text_buf.size() - 1)});
      chars_queued++;
    end
  endtask

  task automatic queue_string(input string s);
    int k;
    text_buf = {};
    for (k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    queue_text_buf();
  endtask

  task automatic put_number(input int v);
    if (v < 10 && $urandom_range(0, 1) == 1) begin
      text_buf.push_back(8'(CH_ZERO + v));
    end else begin
      text_buf.push_back(8'(CH_ZERO + v / 10));
      text_buf.push_back(8'(CH_ZERO + v % 10));
    end
  endtask

  task automatic build_timestamp();
    int k;
    int sel;
    text_buf = {};
    text_buf.push_back(CH_QUOTE);
    put_number($urandom_range(0, 99));
    text_buf.push_back(CH_SLASH);
    sel = $urandom_range(0, 9);
    put_number(sel == 0 ? 0 : (sel == 1 ? $urandom_range(13, 99) : $urandom_range(1, 12)));
    text_buf.push_back(CH_SLASH);
    put_number($urandom_range(0, 7) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 31));
    text_buf.push_back(CH_COMMA);
    put_number($urandom_range(0, 7) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 23));
    text_buf.push_back(CH_COLON);
    put_number($urandom_range(0, 7) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59));
    text_buf.push_back(CH_COLON);
    put_number($urandom_range(0, 7) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59));
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      text_buf.push_back(sel < 4 ? CH_PLUS : (sel < 7 ? CH_MINUS : 8'($urandom_range(0, 255))));
      if ($urandom_range(0, 5) != 0)
        put_number($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 56));
    end
    sel = $urandom_range(0, 3);
    for (k = 0; k < sel; k++)
      text_buf.push_back($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (sel < 5) begin
      k = $urandom_range(1, text_buf.size() - 1);
      while (text_buf.size() > k) void'(text_buf.pop_back());
    end
    queue_text_buf();
  endtask

  task automatic build_noise();
    int k;
    int len;
    text_buf = {};
    len = $urandom_range(1, 10);
    for (k = 0; k < len; k++) text_buf.push_back(8'($urandom_range(0, 255)));
    queue_text_buf();
  endtask

  initial begin
    queue_string("\"24/02/29,23:59:59+08\"");
    queue_string("\"99/12/31,23:59:59-56\"");
    queue_string("\"0/1/1,0:0:0\"");
    queue_string("\"00/01/01,00:00:00");
    queue_string("\"21/00/10,10:10:10+04\"");
    queue_string("\"21/13/10,10:10:10+04\"");
    queue_string("\"21-03/04,05:06:07+00\"");
    queue_string("\"210/03/04,05:06:07+00\"");
    queue_string("\"21/03/04,05\"");
    queue_string("\"21/03/04,05:06:07*12\"");
    queue_string("\"23/07/15,12:30:45+0\"");
    queue_string("\"23/07/15,12:30:45-99xyz");
    queue_string("\"/03/04,05:06:07+00\"");
    text_buf = {8'hFF};
    queue_text_buf();
    text_buf = {8'h00, CH_QUOTE, 8'hFF, 8'h80};
    queue_text_buf();

    while (chars_queued < 800) begin
      if ($urandom_range(0, 9) < 8) begin
        build_timestamp();
      end else begin
        build_noise();
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (!(pending_chars.size() == 0 && !in_tvalid && utc_expected.size() == 0)
           && cycle_count < CYCLE_LIMIT)
      @(negedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (mismatches == 0 && utc_expected.size() == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mtue_pkg.sv
hw/rtl/mtue_ctrl.sv
hw/rtl/mtue_dp.sv
hw/rtl/modem_timestamp_to_utc_epoch.sv
tb/testbench.sv
